// ===== rtl/fq6_inverse_mod_phi9_top_assert.svh =====
// Assertion macros used by the top-level RTL.
`ifndef FQ6_INVERSE_MOD_PHI9_TOP_ASSERT_SVH
`define FQ6_INVERSE_MOD_PHI9_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FQ6_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fq6 assertion failed");

// Next-cycle implication.
`define FQ6_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fq6 assertion failed");

`endif

// ===== rtl/fq6inv_pkg.sv =====
package fq6inv_pkg;

    localparam int COEFF_BITS = 22;
    localparam int SLOTS      = 8;
    localparam int SLOT_BITS  = 3;
    localparam int CNT_BITS   = $clog2(COEFF_BITS);

    typedef logic [COEFF_BITS-1:0] coef_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [SLOT_BITS:0]    deg_t;   // {nonzero, index}

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam coef_t Q_RESET  = coef_t'(3168257);
    localparam slot_t LAST_IN  = slot_t'(5);
    localparam slot_t LAST_SLOT = slot_t'(SLOTS - 1);

    typedef struct packed {
        logic start;
        logic op;
    } alu_cmd_t;

    // highest nonzero slot; top bit clear when the polynomial is zero
    function automatic deg_t poly_deg(input coef_t p [SLOTS]);
        deg_t r;
        r = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (p[k] != '0)
            begin
                r = {1'b1, slot_t'(k)};
            end
        end
        return r;
    endfunction

    // (x - p) mod m with x, p in [0, m-1]
    function automatic coef_t submod(input coef_t x, input coef_t p, input coef_t m);
        logic [COEFF_BITS:0] s;
        if (x >= p)
        begin
            s = {1'b0, x} - {1'b0, p};
        end
        else
        begin
            s = {1'b0, x} + {1'b0, m} - {1'b0, p};
        end
        return coef_t'(s);
    endfunction

endpackage

// ===== rtl/fq6inv_alu.sv =====
module fq6inv_alu (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fq6inv_pkg::alu_cmd_t  cmd,
    input  fq6inv_pkg::coef_t     a,
    input  fq6inv_pkg::coef_t     x,
    input  fq6inv_pkg::coef_t     m,
    output logic                  done,
    output fq6inv_pkg::coef_t     res,
    output fq6inv_pkg::coef_t     quo
);
    import fq6inv_pkg::*;

    // MUL: res = a*x mod m (a < m). DIV: quo = x / m, res = x mod m.
    // One bit of x per cycle, MSB first.
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  op_reg, op_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    coef_t                 a_reg, a_next;
    coef_t                 x_reg, x_next;
    coef_t                 m_reg, m_next;
    coef_t                 acc_reg, acc_next;
    coef_t                 quo_reg, quo_next;

    logic [COEFF_BITS+1:0] t0, t1, t2, add;
    logic                  ge0, bitv;

    always_comb
    begin
        bitv = x_reg[cnt_reg];
        if (op_reg == OP_MUL)
        begin
            add = bitv ? {2'b00, a_reg} : '0;
        end
        else
        begin
            add = {{(COEFF_BITS+1){1'b0}}, bitv};
        end
        t0  = {1'b0, acc_reg, 1'b0} + add;
        ge0 = t0 >= {2'b00, m_reg};
        t1  = ge0 ? t0 - {2'b00, m_reg} : t0;
        if (op_reg == OP_MUL && t1 >= {2'b00, m_reg})
        begin
            t2 = t1 - {2'b00, m_reg};
        end
        else
        begin
            t2 = t1;
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        x_next    = x_reg;
        m_next    = m_reg;
        acc_next  = acc_reg;
        quo_next  = quo_reg;

        if (busy_reg)
        begin
            acc_next = coef_t'(t2);
            quo_next = {quo_reg[COEFF_BITS-2:0], ge0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = CNT_BITS'(COEFF_BITS - 1);
            a_next    = a;
            x_next    = x;
            m_next    = m;
            acc_next  = '0;
            quo_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        x_reg   <= x_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;
    assign quo  = quo_reg;

endmodule

// ===== rtl/fq6_inverse_mod_phi9_top.sv =====
// channel   direction  handshake            payload
// in        to block   in_valid/in_stall    coef_0..coef_5
// out       from block out_valid/out_stall  inv_0..inv_5, not_invertible
// cfg       to block   cfg_wen              cfg_wdata (q modulus)
//
// One word at a time: in_stall is high from accept until the result is taken.
// Every modular product, reduction and integer division runs on one shared
// bit-serial unit; a word with q below two goes straight to the error result,
// and otherwise its time goes mostly to scalar inverses.
// Async active-low reset; q modulus resets to 3168257.
module fq6_inverse_mod_phi9_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  fq6inv_pkg::coef_t    cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  fq6inv_pkg::coef_t    coef_0,
    input  fq6inv_pkg::coef_t    coef_1,
    input  fq6inv_pkg::coef_t    coef_2,
    input  fq6inv_pkg::coef_t    coef_3,
    input  fq6inv_pkg::coef_t    coef_4,
    input  fq6inv_pkg::coef_t    coef_5,
    output logic                 out_valid,
    input  logic                 out_stall,
    output fq6inv_pkg::coef_t    inv_0,
    output fq6inv_pkg::coef_t    inv_1,
    output fq6inv_pkg::coef_t    inv_2,
    output fq6inv_pkg::coef_t    inv_3,
    output fq6inv_pkg::coef_t    inv_4,
    output fq6inv_pkg::coef_t    inv_5,
    output logic                 not_invertible
);
    import fq6inv_pkg::*;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_RED    = 5'd1;
    localparam logic [4:0] S_RED_W  = 5'd2;
    localparam logic [4:0] S_LOOP   = 5'd3;
    localparam logic [4:0] S_FCHK   = 5'd4;
    localparam logic [4:0] S_INV    = 5'd5;
    localparam logic [4:0] S_INV_DW = 5'd6;
    localparam logic [4:0] S_INV_MW = 5'd7;
    localparam logic [4:0] S_QD     = 5'd8;
    localparam logic [4:0] S_QC_W   = 5'd9;
    localparam logic [4:0] S_QI     = 5'd10;
    localparam logic [4:0] S_QI_W   = 5'd11;
    localparam logic [4:0] S_SN_I   = 5'd12;
    localparam logic [4:0] S_SN_J   = 5'd13;
    localparam logic [4:0] S_SN_W   = 5'd14;
    localparam logic [4:0] S_SWAP   = 5'd15;
    localparam logic [4:0] S_FM     = 5'd16;
    localparam logic [4:0] S_FM_W   = 5'd17;
    localparam logic [4:0] S_ERR    = 5'd18;
    localparam logic [4:0] S_OUT    = 5'd19;

    localparam int EXT_W = 6;

    logic [4:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;
    logic       nie_reg, nie_next;
    logic       ret_reg, ret_next;
    coef_t      q_reg;
    coef_t      r0_reg [SLOTS], r0_next [SLOTS];
    coef_t      r1_reg [SLOTS], r1_next [SLOTS];
    coef_t      s0_reg [SLOTS], s0_next [SLOTS];
    coef_t      s1_reg [SLOTS], s1_next [SLOTS];
    coef_t      sn_reg [SLOTS], sn_next [SLOTS];
    coef_t      rem_reg [SLOTS], rem_next [SLOTS];
    coef_t      quo_reg [SLOTS], quo_next [SLOTS];
    coef_t      inv_reg [EXT_W], inv_next [EXT_W];
    coef_t      er_reg, er_next, enr_reg, enr_next;
    coef_t      et_reg, et_next, ent_reg, ent_next;
    coef_t      linv_reg, linv_next, c_reg, c_next;
    slot_t      idx_reg, idx_next, d_reg, d_next, j_reg, j_next;

    deg_t       deg0, deg1, degs;
    slot_t      sh, ri;
    logic [SLOT_BITS:0] sum;

    alu_cmd_t   cmd;
    coef_t      alu_a, alu_x, alu_m, alu_res, alu_quo;
    logic       alu_done;

    fq6inv_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .a     (alu_a),
        .x     (alu_x),
        .m     (alu_m),
        .done  (alu_done),
        .res   (alu_res),
        .quo   (alu_quo)
    );

    always_comb
    begin
        deg0 = poly_deg(r0_reg);
        deg1 = poly_deg(r1_reg);
        degs = poly_deg(s1_reg);
        sh   = d_reg - deg1[SLOT_BITS-1:0];
        ri   = idx_reg + sh;
        sum  = {1'b0, idx_reg} + {1'b0, j_reg};

        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        nie_next    = nie_reg;
        ret_next    = ret_reg;
        r0_next     = r0_reg;
        r1_next     = r1_reg;
        s0_next     = s0_reg;
        s1_next     = s1_reg;
        sn_next     = sn_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        inv_next    = inv_reg;
        er_next     = er_reg;
        enr_next    = enr_reg;
        et_next     = et_reg;
        ent_next    = ent_reg;
        linv_next   = linv_reg;
        c_next      = c_reg;
        idx_next    = idx_reg;
        d_next      = d_reg;
        j_next      = j_reg;

        cmd.start = 1'b0;
        cmd.op    = OP_MUL;
        alu_a     = '0;
        alu_x     = '0;
        alu_m     = q_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    r1_next[0] = coef_0;
                    r1_next[1] = coef_1;
                    r1_next[2] = coef_2;
                    r1_next[3] = coef_3;
                    r1_next[4] = coef_4;
                    r1_next[5] = coef_5;
                    r1_next[6] = '0;
                    r1_next[7] = '0;
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        r0_next[k] = (k == 0 || k == 3 || k == 6) ? coef_t'(1) : '0;
                        s0_next[k] = '0;
                        s1_next[k] = (k == 0) ? coef_t'(1) : '0;
                    end
                    idx_next   = '0;
                    state_next = (q_reg < coef_t'(2)) ? S_ERR : S_RED;
                end
            end
            S_RED:
            begin
                cmd.start  = 1'b1;
                alu_a      = coef_t'(1);
                alu_x      = r1_reg[idx_reg];
                state_next = S_RED_W;
            end
            S_RED_W:
            begin
                if (alu_done)
                begin
                    r1_next[idx_reg] = alu_res;
                    if (idx_reg == LAST_IN)
                    begin
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RED;
                    end
                end
            end
            S_LOOP:
            begin
                if (!deg1[SLOT_BITS])
                begin
                    state_next = S_FCHK;
                end
                else
                begin
                    rem_next   = r0_reg;
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        quo_next[k] = '0;
                    end
                    er_next    = q_reg;
                    enr_next   = r1_reg[deg1[SLOT_BITS-1:0]];
                    et_next    = '0;
                    ent_next   = coef_t'(1);
                    ret_next   = 1'b0;
                    state_next = S_INV;
                end
            end
            S_FCHK:
            begin
                if (!deg0[SLOT_BITS] || deg0[SLOT_BITS-1:0] != '0)
                begin
                    state_next = S_ERR;
                end
                else
                begin
                    er_next    = q_reg;
                    enr_next   = r0_reg[0];
                    et_next    = '0;
                    ent_next   = coef_t'(1);
                    ret_next   = 1'b1;
                    state_next = S_INV;
                end
            end
            // integer extended Euclid, cofactor kept mod q
            S_INV:
            begin
                if (enr_reg == '0)
                begin
                    if (er_reg != coef_t'(1))
                    begin
                        state_next = S_ERR;
                    end
                    else if (ret_reg)
                    begin
                        idx_next   = '0;
                        state_next = S_FM;
                    end
                    else
                    begin
                        linv_next  = et_reg;
                        d_next     = deg0[SLOT_BITS-1:0];
                        state_next = S_QD;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = OP_DIV;
                    alu_x      = er_reg;
                    alu_m      = enr_reg;
                    state_next = S_INV_DW;
                end
            end
            S_INV_DW:
            begin
                if (alu_done)
                begin
                    er_next    = enr_reg;
                    enr_next   = alu_res;
                    cmd.start  = 1'b1;
                    alu_a      = ent_reg;
                    alu_x      = alu_quo;
                    state_next = S_INV_MW;
                end
            end
            S_INV_MW:
            begin
                if (alu_done)
                begin
                    et_next    = ent_reg;
                    ent_next   = submod(et_reg, alu_res, q_reg);
                    state_next = S_INV;
                end
            end
            // polynomial long division, top term down
            S_QD:
            begin
                if (rem_reg[d_reg] == '0)
                begin
                    if (d_reg == deg1[SLOT_BITS-1:0])
                    begin
                        sn_next    = s0_reg;
                        idx_next   = '0;
                        state_next = S_SN_I;
                    end
                    else
                    begin
                        d_next = d_reg - 1'b1;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    alu_a      = rem_reg[d_reg];
                    alu_x      = linv_reg;
                    state_next = S_QC_W;
                end
            end
            S_QC_W:
            begin
                if (alu_done)
                begin
                    c_next       = alu_res;
                    quo_next[sh] = alu_res;
                    idx_next     = '0;
                    state_next   = S_QI;
                end
            end
            S_QI:
            begin
                cmd.start  = 1'b1;
                alu_a      = c_reg;
                alu_x      = r1_reg[idx_reg];
                state_next = S_QI_W;
            end
            S_QI_W:
            begin
                if (alu_done)
                begin
                    rem_next[ri] = submod(rem_reg[ri], alu_res, q_reg);
                    if (idx_reg != deg1[SLOT_BITS-1:0])
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_QI;
                    end
                    else if (d_reg == deg1[SLOT_BITS-1:0])
                    begin
                        sn_next    = s0_reg;
                        idx_next   = '0;
                        state_next = S_SN_I;
                    end
                    else
                    begin
                        d_next     = d_reg - 1'b1;
                        state_next = S_QD;
                    end
                end
            end
            // sn = s0 - quo * s1
            S_SN_I:
            begin
                if (quo_reg[idx_reg] == '0 || !degs[SLOT_BITS])
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_next = S_SWAP;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_SN_J;
                end
            end
            S_SN_J:
            begin
                cmd.start  = 1'b1;
                alu_a      = quo_reg[idx_reg];
                alu_x      = s1_reg[j_reg];
                state_next = S_SN_W;
            end
            S_SN_W:
            begin
                if (alu_done)
                begin
                    if (!sum[SLOT_BITS])
                    begin
                        sn_next[sum[SLOT_BITS-1:0]] =
                            submod(sn_reg[sum[SLOT_BITS-1:0]], alu_res, q_reg);
                    end
                    if (j_reg != degs[SLOT_BITS-1:0])
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_SN_J;
                    end
                    else if (idx_reg == LAST_SLOT)
                    begin
                        state_next = S_SWAP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_SN_I;
                    end
                end
            end
            S_SWAP:
            begin
                r0_next    = r1_reg;
                r1_next    = rem_reg;
                s0_next    = s1_reg;
                s1_next    = sn_reg;
                state_next = S_LOOP;
            end
            S_FM:
            begin
                cmd.start  = 1'b1;
                alu_a      = s0_reg[idx_reg];
                alu_x      = et_reg;
                state_next = S_FM_W;
            end
            S_FM_W:
            begin
                if (alu_done)
                begin
                    inv_next[idx_reg] = alu_res;
                    if (idx_reg == LAST_IN)
                    begin
                        nie_next    = 1'b0;
                        ovalid_next = 1'b1;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_FM;
                    end
                end
            end
            S_ERR:
            begin
                for (int k = 0; k < EXT_W; k++)
                begin
                    inv_next[k] = '0;
                end
                nie_next    = 1'b1;
                ovalid_next = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    ovalid_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            q_reg      <= Q_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            if (cfg_wen)
            begin
                q_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nie_reg  <= nie_next;
        ret_reg  <= ret_next;
        r0_reg   <= r0_next;
        r1_reg   <= r1_next;
        s0_reg   <= s0_next;
        s1_reg   <= s1_next;
        sn_reg   <= sn_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        inv_reg  <= inv_next;
        er_reg   <= er_next;
        enr_reg  <= enr_next;
        et_reg   <= et_next;
        ent_reg  <= ent_next;
        linv_reg <= linv_next;
        c_reg    <= c_next;
        idx_reg  <= idx_next;
        d_reg    <= d_next;
        j_reg    <= j_next;
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = ovalid_reg;
    assign inv_0          = inv_reg[0];
    assign inv_1          = inv_reg[1];
    assign inv_2          = inv_reg[2];
    assign inv_3          = inv_reg[3];
    assign inv_4          = inv_reg[4];
    assign inv_5          = inv_reg[5];
    assign not_invertible = nie_reg;

`include "fq6_inverse_mod_phi9_top_assert.svh"

    `FQ6_AST_IMP(a_err_zero, out_valid && not_invertible,
        inv_0 == '0 && inv_1 == '0 && inv_2 == '0 && inv_3 == '0 && inv_4 == '0 && inv_5 == '0)
    `FQ6_AST_IMP(a_valid_only_out, state_reg != S_OUT, !out_valid)
    `FQ6_AST_NXT(a_accept_busy, in_valid && !in_stall, in_stall && !out_valid)
    `FQ6_AST_IMP(a_alu_idle_start, cmd.start, !alu_done || state_reg == S_INV_DW)

endmodule
